### hw/rtl/wildcard_line_matcher_core_macros.svh
// ---------------------------------------------------------------------------
// wildcard line matcher assertion macros
// concurrent assertion shorthands, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef WILDCARD_LINE_MATCHER_CORE_MACROS_SVH
`define WILDCARD_LINE_MATCHER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define WLM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wlm assertion failed");

`define WLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wlm assertion failed");

`else

`define WLM_ASSERT_NOW(label, clk, rst, ante, cons)

`define WLM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/wlm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlm_pkg
// operation and result codes and byte constants of the wildcard line matcher
// ---------------------------------------------------------------------------
package wlm_pkg;

  typedef enum logic [1:0] {
    OP_PAT_CHAR = 2'd0,
    OP_PAT_END  = 2'd1,
    OP_TEXT     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_USUAL  = 2'd0,
    RES_FIT    = 2'd1,
    RES_MISFIT = 2'd2,
    RES_ERROR  = 2'd3
  } res_t;

  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;
  localparam logic [7:0] STAR_BYTE = 8'h2A;

endpackage

### hw/rtl/wlm_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlm_in_if
// input channel: operation code and byte
// ---------------------------------------------------------------------------
interface wlm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink (input valid, input op, input ch, output ready);
endinterface

### hw/rtl/wlm_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlm_out_if
// result channel: two-bit answer per beat
// ---------------------------------------------------------------------------
interface wlm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] meaning;

  modport source (output valid, output meaning, input ready);
  modport sink (input valid, input meaning, output ready);
endinterface

### hw/rtl/wlm_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlm_table
// pattern table memory, one write port, one registered read port with
// write-to-read forwarding
// ---------------------------------------------------------------------------
module wlm_table #(
  parameter int DEPTH  = 33,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 15
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/wlm_matcher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlm_matcher
// pattern loader and match state; the entry at the current match position
// is kept prefetched from the table so each beat resolves combinationally in its own cycle
// ---------------------------------------------------------------------------
module wlm_matcher import wlm_pkg::*; #(
  parameter int MAX_PATTERN_CHARS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [1:0] op,
  input  logic [7:0] ch,
  output logic [1:0] res
);

  localparam int DEPTH  = MAX_PATTERN_CHARS + 1;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 8 + IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PATTERN_CHARS);

  typedef struct packed {
    logic [7:0]       chr;
    logic [IDX_W-1:0] roll;
    logic             reject;
  } entry_t;

  logic [IDX_W-1:0] insert_count, insert_count_next;
  logic [IDX_W-1:0] load_roll_index, load_roll_index_next;
  logic             seen_star, seen_star_next;
  logic             pattern_ready, pattern_ready_next;
  logic             pattern_overflow, pattern_overflow_next;
  logic [IDX_W-1:0] match_index, match_index_next;
  logic             line_rejected, line_rejected_next;

  logic              tbl_we;
  entry_t            tbl_wentry;
  logic [DATA_W-1:0] tbl_rdata;
  entry_t            cur;

  assign cur = entry_t'(tbl_rdata);

  always_comb begin
    logic ovf;
    insert_count_next     = insert_count;
    load_roll_index_next  = load_roll_index;
    seen_star_next        = seen_star;
    pattern_ready_next    = pattern_ready;
    pattern_overflow_next = pattern_overflow;
    match_index_next      = match_index;
    line_rejected_next    = line_rejected;
    tbl_we                = 1'b0;
    tbl_wentry.chr        = ch;
    tbl_wentry.roll       = load_roll_index;
    tbl_wentry.reject     = !seen_star;
    res                   = RES_USUAL;
    ovf                   = pattern_overflow;
    unique case (op_t'(op))
      OP_PAT_CHAR: begin
        if (pattern_ready) begin
          res = RES_ERROR;
        end else begin
          if (ch == STAR_BYTE) begin
            seen_star_next       = 1'b1;
            load_roll_index_next = insert_count;
          end else if (insert_count < LAST_IDX) begin
            tbl_we            = acc;
            insert_count_next = insert_count + IDX_W'(1);
          end else begin
            ovf = 1'b1;
          end
          pattern_overflow_next = ovf;
          res = ovf ? RES_ERROR : RES_USUAL;
        end
      end
      OP_PAT_END: begin
        if (pattern_ready) begin
          res = RES_ERROR;
        end else begin
          tbl_wentry.chr     = LF_BYTE;
          tbl_we             = acc;
          pattern_ready_next = 1'b1;
          match_index_next   = '0;
          line_rejected_next = 1'b0;
          res = pattern_overflow ? RES_ERROR : RES_USUAL;
        end
      end
      OP_TEXT: begin
        if (!pattern_ready || pattern_overflow) begin
          res = RES_ERROR;
        end else if (ch == CR_BYTE) begin
          res = RES_USUAL;
        end else if (ch == LF_BYTE) begin
          res = (cur.chr == LF_BYTE) ? RES_FIT : RES_MISFIT;
          match_index_next   = '0;
          line_rejected_next = 1'b0;
        end else if ((cur.chr == ch) || (cur.chr == ANY_BYTE)) begin
          if (!line_rejected && (match_index != LAST_IDX)) begin
            match_index_next = match_index + IDX_W'(1);
          end
        end else if (cur.reject) begin
          line_rejected_next = 1'b1;
        end else begin
          match_index_next = cur.roll;
        end
      end
      OP_CLEAR: begin
        insert_count_next     = '0;
        load_roll_index_next  = '0;
        seen_star_next        = 1'b0;
        pattern_ready_next    = 1'b0;
        pattern_overflow_next = 1'b0;
        match_index_next      = '0;
        line_rejected_next    = 1'b0;
      end
      default: begin
        res = RES_ERROR;
      end
    endcase
    if (!acc) begin
      match_index_next = match_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_count     <= '0;
      load_roll_index  <= '0;
      seen_star        <= 1'b0;
      pattern_ready    <= 1'b0;
      pattern_overflow <= 1'b0;
      match_index      <= '0;
      line_rejected    <= 1'b0;
    end else if (acc) begin
      insert_count     <= insert_count_next;
      load_roll_index  <= load_roll_index_next;
      seen_star        <= seen_star_next;
      pattern_ready    <= pattern_ready_next;
      pattern_overflow <= pattern_overflow_next;
      match_index      <= match_index_next;
      line_rejected    <= line_rejected_next;
    end
  end

  // read address follows the next match position so the entry is ready
  wlm_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (insert_count),
    .wdata (tbl_wentry),
    .raddr (match_index_next),
    .rdata (tbl_rdata)
  );

endmodule

### hw/rtl/wildcard_line_matcher_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_line_matcher_core
// loads a wildcard pattern ('*' any run, '?' any byte) and judges text lines
// at each line feed; one answer per beat
// ---------------------------------------------------------------------------
//   channel   dir   payload            use
//   items     in    op[1:0], ch[7:0]   pattern chars, end mark, text, clear
//   results   out   meaning[1:0]       usual, fit, misfit, error
//
// one beat per cycle unless stalled, one answer per beat in the next cycle
// the match index, table read and index update close in a loop through the
// registered table read; synchronous reset clears pattern and match state;
// table contents are not cleared and are only read where already written
// a stalled answer holds in the output register; a new beat is taken in the
// same cycle the pending answer leaves
// ---------------------------------------------------------------------------
`include "wildcard_line_matcher_core_macros.svh"

module wildcard_line_matcher_core import wlm_pkg::*; #(
  parameter int MAX_PATTERN_CHARS = 32
) (
  input logic      clk,
  input logic      rst,
  wlm_in_if.sink   items,
  wlm_out_if.source results
);

  logic       acc;
  logic [1:0] res;
  logic       out_valid;
  logic [1:0] out_meaning;

  assign items.ready     = !out_valid || results.ready;
  assign acc             = items.valid && items.ready;
  assign results.valid   = out_valid;
  assign results.meaning = out_meaning;

  wlm_matcher #(
    .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS)
  ) u_matcher (
    .clk (clk),
    .rst (rst),
    .acc (acc),
    .op  (items.op),
    .ch  (items.ch),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_meaning <= res;
    end
  end

  `WLM_ASSERT_NEXT(a_accept_gives_answer, clk, rst, acc, out_valid)
  `WLM_ASSERT_NOW(a_no_overrun, clk, rst, out_valid && !results.ready, !acc)
  `WLM_ASSERT_NEXT(a_drain_empties, clk, rst, out_valid && results.ready && !acc, !out_valid)

endmodule

### sim/wlm_verdict_board_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlm_verdict_board_pkg
// tracks pattern load and line match state and checks every answer beat
// ---------------------------------------------------------------------------
package wlm_verdict_board_pkg;
  import wlm_pkg::*;

  localparam int PATTERN_CAP = 32;
  localparam int TABLE_DEPTH = PATTERN_CAP + 1;

  typedef struct packed {
    logic [7:0] chr;
    logic [5:0] roll;
    logic       reject;
  } pat_entry_t;

  class line_verdict_board;
    pat_entry_t  entries[TABLE_DEPTH];
    int unsigned loaded;
    int unsigned roll_mark;
    int unsigned match_pos;
    bit          star_seen;
    bit          pattern_done;
    bit          overflowed;
    bit          rejected;
    res_t        answers_due[$];
    int unsigned mismatches;

    function new();
      clear_pattern();
      mismatches = 0;
    endfunction

    function void clear_pattern();
      loaded       = 0;
      roll_mark    = 0;
      match_pos    = 0;
      star_seen    = 1'b0;
      pattern_done = 1'b0;
      overflowed   = 1'b0;
      rejected     = 1'b0;
    endfunction

    function res_t predict_answer(op_t op, logic [7:0] ch);
      res_t        ans;
      int unsigned pos;
      pat_entry_t  e;
      ans = RES_USUAL;
      case (op)
        OP_PAT_CHAR: begin
          if (pattern_done) begin
            ans = RES_ERROR;
          end else begin
            if (ch == STAR_BYTE) begin
              star_seen = 1'b1;
              roll_mark = loaded;
            end else if (loaded < PATTERN_CAP) begin
              entries[loaded].chr    = ch;
              entries[loaded].roll   = 6'(roll_mark);
              entries[loaded].reject = !star_seen;
              loaded++;
            end else begin
              overflowed = 1'b1;
            end
            if (overflowed) ans = RES_ERROR;
          end
        end
        OP_PAT_END: begin
          if (pattern_done) begin
            ans = RES_ERROR;
          end else begin
            entries[loaded].chr    = LF_BYTE;
            entries[loaded].roll   = 6'(roll_mark);
            entries[loaded].reject = !star_seen;
            pattern_done = 1'b1;
            match_pos    = 0;
            rejected     = 1'b0;
            if (overflowed) ans = RES_ERROR;
          end
        end
        OP_TEXT: begin
          if (!pattern_done || overflowed) begin
            ans = RES_ERROR;
          end else if (ch != CR_BYTE) begin
            pos = (match_pos < TABLE_DEPTH) ? match_pos : TABLE_DEPTH - 1;
            e = entries[pos];
            if (ch == LF_BYTE) begin
              ans       = (e.chr == LF_BYTE) ? RES_FIT : RES_MISFIT;
              match_pos = 0;
              rejected  = 1'b0;
            end else if (e.chr == ch || e.chr == ANY_BYTE) begin
              if (!rejected && pos + 1 < TABLE_DEPTH) match_pos = pos + 1;
            end else if (e.reject) begin
              rejected = 1'b1;
            end else begin
              match_pos = e.roll;
            end
          end
        end
        default: begin
          clear_pattern();
        end
      endcase
      return ans;
    endfunction

    function void note_item(op_t op, logic [7:0] ch);
      answers_due.push_back(predict_answer(op, ch));
    endfunction

    function void check_answer(logic [1:0] meaning);
      res_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected answer, expected none, actual %0d", $time, meaning);
        return;
      end
      want = answers_due.pop_front();
      if (meaning !== want) begin
        mismatches++;
        $display("%0t: answer mismatch, expected %0d (%s), actual %0d",
                 $time, want, want.name(), meaning);
      end
    endfunction
  endclass

endpackage

### sim/wildcard_line_matcher_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_line_matcher_core_test
// drives pattern loads, text lines, clears and noise into the matcher with
// random bursts and output stalls, and checks every answer against a local
// model of the pattern table and match index
// ---------------------------------------------------------------------------
module wildcard_line_matcher_core_test;
  import wlm_pkg::*;
  import wlm_verdict_board_pkg::*;

  localparam int ITEM_TARGET   = 1700;
  localparam int HOLD_AT_ITEM  = 400;
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_LIMIT    = 2000;

  logic clk;
  logic rst;

  wlm_in_if  items_if ();
  wlm_out_if results_if ();

  line_verdict_board board;
  int unsigned       items_sent;
  int unsigned       burst_left;
  int unsigned       idle_cycles;

  wildcard_line_matcher_core #(
    .MAX_PATTERN_CHARS(PATTERN_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .items(items_if),
    .results(results_if)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic send_item(op_t op, logic [7:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    items_if.valid <= 1'b1;
    items_if.op    <= op;
    items_if.ch    <= ch;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    board.note_item(op, ch);
    items_sent++;
  endtask

  task automatic run_pattern_session();
    logic [7:0] pat[$];
    logic [7:0] line[$];
    logic [7:0] c;
    int unsigned n;
    int unsigned r;
    if ($urandom_range(0, 4) != 0) send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 38) : $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r < 4) c = STAR_BYTE;
      else if (r < 7) c = ANY_BYTE;
      else if (r == 7) c = 8'($urandom_range(0, 255));
      else if (r == 8) c = ($urandom_range(0, 1) == 1) ? LF_BYTE : CR_BYTE;
      else c = 8'($urandom_range(8'h61, 8'h63));
      pat.push_back(c);
      send_item(OP_PAT_CHAR, c);
    end
    if ($urandom_range(0, 19) != 0) send_item(OP_PAT_END, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 6)) begin
      line.delete();
      foreach (pat[i]) begin
        if (pat[i] == STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(8'h61, 8'h63)));
        end else if (pat[i] == ANY_BYTE) begin
          line.push_back(8'($urandom_range(0, 255)));
        end else if (pat[i] != LF_BYTE) begin
          line.push_back(pat[i]);
        end
      end
      r = $urandom_range(0, 7);
      if (r == 0 && line.size() > 0) begin
        line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(8'h61, 8'h63));
      end else if (r == 1 && line.size() > 0) begin
        line.delete($urandom_range(0, line.size() - 1));
      end else if (r == 2) begin
        line.insert($urandom_range(0, line.size()), CR_BYTE);
      end else if (r == 3) begin
        line.push_back(8'($urandom_range(0, 255)));
      end
      foreach (line[i]) send_item(OP_TEXT, line[i]);
      send_item(OP_TEXT, LF_BYTE);
    end
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // result beats
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      board.check_answer(results_if.meaning);
    end
  end

  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int unsigned cyc;
    bit          held;
    cyc  = 0;
    held = 1'b0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && items_sent >= HOLD_AT_ITEM) begin
        held = 1'b1;
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((cyc / 200) % 4)
          0: results_if.ready <= 1'b1;
          1: results_if.ready <= ($urandom_range(0, 1) == 1);
          2: results_if.ready <= ($urandom_range(0, 9) != 0);
          default: results_if.ready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    board       = new();
    items_sent  = 0;
    burst_left  = 0;
    rst            <= 1'b1;
    items_if.valid <= 1'b0;
    items_if.op    <= OP_CLEAR;
    items_if.ch    <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // text before any pattern, then a*?<ff> with late loads
    send_item(OP_TEXT, "a");
    send_item(OP_PAT_CHAR, "a");
    send_item(OP_PAT_CHAR, STAR_BYTE);
    send_item(OP_PAT_CHAR, ANY_BYTE);
    send_item(OP_PAT_CHAR, 8'hFF);
    send_item(OP_PAT_END, 8'h00);
    send_item(OP_PAT_CHAR, "x");
    send_item(OP_PAT_END, 8'hFF);
    send_item(OP_TEXT, "a");
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, CR_BYTE);
    send_item(OP_TEXT, "q");
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, LF_BYTE);
    send_item(OP_TEXT, "b");
    send_item(OP_TEXT, LF_BYTE);
    // line feed and carriage return stored in the pattern
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_PAT_CHAR, LF_BYTE);
    send_item(OP_PAT_CHAR, CR_BYTE);
    send_item(OP_PAT_END, 8'h00);
    send_item(OP_TEXT, CR_BYTE);
    send_item(OP_TEXT, LF_BYTE);
    // empty pattern
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_PAT_END, 8'h00);
    send_item(OP_TEXT, LF_BYTE);

    while (items_sent < ITEM_TARGET) run_pattern_session();

    items_if.valid <= 1'b0;
    while (board.answers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### wildcard_line_matcher_core.f
+incdir+hw/rtl
hw/rtl/wlm_pkg.sv
hw/rtl/wlm_in_if.sv
hw/rtl/wlm_out_if.sv
hw/rtl/wlm_table.sv
hw/rtl/wlm_matcher.sv
hw/rtl/wildcard_line_matcher_core.sv
sim/wlm_verdict_board_pkg.sv
sim/wildcard_line_matcher_core_test.sv
